### hdl/rcm_pkg.sv
package rcm_pkg;

  localparam int FRAC_BITS = 6;
  localparam int POS_W = 17;
  localparam int LEN_W = 11;
  localparam int ID_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [1:0] AMP_MAX = 2'd3;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_PLAY  = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_QUERY = 3'd3;
  localparam logic [2:0] REQ_WRITE = 3'd4;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [7:0]       wave_addr;
    logic [7:0]       wave_data;
    logic [LEN_W-1:0] sample_count;
    logic [7:0]       step;
    logic [ID_W-1:0]  clip_id;
  } rcm_req_t;

  typedef struct packed {
    logic            rumble_on;
    logic [ID_W-1:0] new_id;
    logic            is_active;
  } rcm_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_ACCUM,
    ST_FINISH
  } rcm_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic walk_start;
    logic accum;
    logic finish;
  } rcm_cmd_t;

  typedef struct packed {
    logic walk;
    logic last_voice;
  } rcm_sts_t;

endpackage

### hdl/rcm_ctrl.sv
module rcm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rcm_pkg::rcm_sts_t sts,
  output rcm_pkg::rcm_cmd_t cmd,
  output logic             busy
);
  import rcm_pkg::*;

  rcm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
        if (start) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // An unpaused tick walks the voices; everything else finishes here.
        if (sts.walk) begin
          cmd.walk_start = 1'b1;
          state_next = ST_READ;
        end else begin
          cmd.exec = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_next = sts.last_voice ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/rcm_datapath.sv
module rcm_datapath #(
  parameter int VOICES = 4,
  parameter int WAVE_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  rcm_pkg::rcm_req_t req,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  rcm_pkg::rcm_cmd_t cmd,
  output rcm_pkg::rcm_sts_t sts,
  output logic              done,
  output rcm_pkg::rcm_rsp_t rsp
);
  import rcm_pkg::*;

  localparam int AW = $clog2(WAVE_BYTES);
  localparam int SW = (AW > 10) ? AW : 10;
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  rcm_req_t req_q;
  logic     paused;

  logic [7:0] mem [WAVE_BYTES];
  logic [7:0] rd_data;

  logic [VOICES-1:0] voice_busy;
  logic [ID_W-1:0]   voice_id  [VOICES];
  logic [7:0]        voice_start [VOICES];
  logic [LEN_W-1:0]  voice_length [VOICES];
  logic [7:0]        voice_rate [VOICES];
  logic [POS_W-1:0]  voice_position [VOICES];

  logic [ID_W-1:0] id_counter;
  logic [1:0]      pwm_phase;
  logic [1:0]      amp;
  logic [VW-1:0]   vcnt;

  logic            free_found, match_found;
  logic [VW-1:0]   free_idx, match_idx;
  logic [LEN_W-1:0] cur_idx;
  logic            cur_retire;
  logic [SW-1:0]   rd_sum, wr_wide;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [1:0]      sample;
  logic [2:0]      amp_sum;
  logic [POS_W:0]  pos_sum;
  logic [POS_W-1:0] pos_next;
  logic [ID_W-1:0] id_inc;
  logic            is_play, is_stop, is_query, is_write;
  logic            rumble;

  assign is_play  = req_q.req_type == REQ_PLAY;
  assign is_stop  = req_q.req_type == REQ_STOP;
  assign is_query = req_q.req_type == REQ_QUERY;
  assign is_write = req_q.req_type == REQ_WRITE;

  assign sts.walk = (req_q.req_type == REQ_TICK) && !paused;
  assign sts.last_voice = vcnt == VW'(VOICES - 1);

  // Lowest free voice and lowest busy voice holding the requested id.
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    match_found = 1'b0;
    match_idx = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!voice_busy[v]) begin
        free_found = 1'b1;
        free_idx = VW'(v);
      end
      if (voice_busy[v] && voice_id[v] == req_q.clip_id) begin
        match_found = 1'b1;
        match_idx = VW'(v);
      end
    end
  end

  assign cur_idx = voice_position[vcnt][POS_W-1:FRAC_BITS];
  assign cur_retire = cur_idx >= voice_length[vcnt];
  assign rd_sum = SW'(voice_start[vcnt]) + SW'(cur_idx[LEN_W-1:2]);
  assign rd_addr = rd_sum[AW-1:0];
  assign wr_wide = SW'(req_q.wave_addr);
  assign wr_addr = wr_wide[AW-1:0];

  // Position bits are stable between the read and accumulate beats, so
  // the lane select here matches the byte fetched.
  always_comb begin
    unique case (cur_idx[1:0])
      2'd0: sample = rd_data[7:6];
      2'd1: sample = rd_data[5:4];
      2'd2: sample = rd_data[3:2];
      default: sample = rd_data[1:0];
    endcase
  end

  assign amp_sum = {1'b0, amp} + {1'b0, sample};
  assign pos_sum = {1'b0, voice_position[vcnt]} + (POS_W+1)'(voice_rate[vcnt]);
  assign pos_next = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
  assign id_inc = id_counter + 1'b1;
  assign rumble = (amp == AMP_MAX) || (amp > pwm_phase);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paused <= 1'b0;
    end else if (cfg_we) begin
      paused <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_write) begin
      mem[wr_addr] <= req_q.wave_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_busy <= '0;
    end else begin
      if (cmd.exec && is_play && free_found) begin
        voice_busy[free_idx] <= 1'b1;
        voice_id[free_idx] <= id_counter;
        voice_start[free_idx] <= req_q.wave_addr;
        voice_length[free_idx] <= req_q.sample_count;
        voice_rate[free_idx] <= req_q.step;
        voice_position[free_idx] <= '0;
      end
      if (cmd.exec && is_stop && match_found) begin
        voice_busy[match_idx] <= 1'b0;
      end
      if (cmd.accum && voice_busy[vcnt]) begin
        if (cur_retire) begin
          voice_busy[vcnt] <= 1'b0;
        end else begin
          voice_position[vcnt] <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= ID_W'(1);
      pwm_phase <= '0;
    end else begin
      if (cmd.exec && is_play && free_found) begin
        // Id zero is reserved for "no voice".
        id_counter <= (id_inc == '0) ? ID_W'(1) : id_inc;
      end
      if (cmd.finish) begin
        pwm_phase <= pwm_phase + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      amp <= '0;
      vcnt <= '0;
    end else if (cmd.accum) begin
      vcnt <= vcnt + 1'b1;
      if (voice_busy[vcnt] && !cur_retire) begin
        amp <= amp_sum[2] ? AMP_MAX : amp_sum[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec | cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.rumble_on <= 1'b0;
      rsp.new_id <= (is_play && free_found) ? id_counter : '0;
      rsp.is_active <= is_query && match_found;
    end else if (cmd.finish) begin
      rsp.rumble_on <= rumble;
      rsp.new_id <= '0;
      rsp.is_active <= 1'b0;
    end
  end

endmodule

### hdl/rumble_clip_mixer.sv
// Channel  | Ports                    | Handshake
// ---------+--------------------------+-----------------------------------
// request  | start, busy, req         | beat taken when start && !busy
// result   | done, rsp                | one-cycle strobe, always taken
// config   | cfg_we, cfg_wdata        | paused written when cfg_we is high
//
// Play, stop, query, write and a paused tick return to idle from dispatch;
// the result strobes in the cycle busy drops. An unpaused tick walks the
// voices one at a time through the single wave memory read port, with a
// read state and an accumulate state per voice. Synchronous reset clears
// voices, phase and paused, and sets the id counter to one; the wave
// memory holds whatever it held until written. WAVE_BYTES is a power of
// two. The receiver cannot stall; each result is shown for exactly one cycle.
module rumble_clip_mixer #(
  parameter int VOICES = 4,
  parameter int WAVE_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rcm_pkg::rcm_req_t req,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              done,
  output rcm_pkg::rcm_rsp_t rsp
);
  import rcm_pkg::*;

  rcm_cmd_t cmd;
  rcm_sts_t sts;

  rcm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rcm_datapath #(
    .VOICES     (VOICES),
    .WAVE_BYTES (WAVE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

### hdl/rcm_check.sv
module rcm_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input rcm_pkg::rcm_rsp_t rsp
);
  import rcm_pkg::*;

  // A result only appears once the block is free for the next beat.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobed right after accept");

  // Each request type drives at most one result field.
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({rsp.rumble_on, rsp.is_active, rsp.new_id != '0}) <= 1))
    else $error("more than one result field set");

endmodule

bind rumble_clip_mixer rcm_check u_check (.*);
